// File: hw/rtl/dhsp_pkg.sv
// types and constants shared by the heater setpoint panel
// no dependencies; used by dhsp_debounce and the top level
`default_nettype none

package dhsp_pkg;

    localparam int TIME_W   = 32;
    localparam int MS_W     = 16;
    localparam int STEP_W   = 8;
    localparam int TEMP_W   = 10;
    localparam int BAR_W    = 3;
    localparam int DUTY_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [MS_W-1:0]   DEBOUNCE_RST = 16'd100;
    localparam logic [MS_W-1:0]   LONG_RST     = 16'd1000;
    localparam logic [STEP_W-1:0] STEP_RST     = 8'd20;
    localparam logic [TEMP_W-1:0] DEFAULT_RST  = 10'd400;
    localparam logic [TEMP_W-1:0] MAX_RST      = 10'd1020;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE = 3'd0,
        REG_LONG     = 3'd1,
        REG_STEP     = 3'd2,
        REG_DEFAULT  = 3'd3,
        REG_MAX      = 3'd4
    } cfg_reg_t;

    // status of one filtered button after the current sample
    typedef struct packed {
        logic              level;
        logic              rise;
        logic [TIME_W-1:0] held_ms;
    } btn_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/dhsp_debounce.sv
// debounce filter for one button level with its own change timestamp
// depends on dhsp_pkg
`default_nettype none

module dhsp_debounce (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       update,
    input  wire logic                       raw_level,
    input  wire logic [dhsp_pkg::TIME_W-1:0] now_ms,
    input  wire logic [dhsp_pkg::MS_W-1:0]   debounce_ms,
    output dhsp_pkg::btn_status_t            status
);
    import dhsp_pkg::*;

    logic              level_reg;
    logic              level_next;
    logic              last_raw_reg;
    logic [TIME_W-1:0] change_time_reg;
    logic [TIME_W-1:0] change_time_next;
    logic [TIME_W-1:0] elapsed;

    always_comb
    begin
        change_time_next = (raw_level != last_raw_reg) ? now_ms : change_time_reg;
        // wraps modulo 2^32
        elapsed    = now_ms - change_time_next;
        level_next = (elapsed > {{(TIME_W-MS_W){1'b0}}, debounce_ms}) ? raw_level : level_reg;
        status.level   = level_next;
        status.rise    = level_next & ~level_reg;
        status.held_ms = elapsed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg       <= 1'b0;
            last_raw_reg    <= 1'b0;
            change_time_reg <= '0;
        end
        else if (update)
        begin
            level_reg       <= level_next;
            last_raw_reg    <= raw_level;
            change_time_reg <= change_time_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/debounced_heater_setpoint_panel_unit.sv
// top level of the heater setpoint panel: input register, button filters,
// setpoint and bar update, result register; depends on dhsp_pkg and dhsp_debounce
`default_nettype none

// One sample tick is taken per clock cycle while in_ready is high. Each sample passes
// the registers in order: it is first captured in an input register, then the three
// debounce filters, the bar counter and the setpoint adder/clamp update in one pass
// and the result is captured in an output register. A sample may wait in the input
// register while a result is held by out_ready low, so the input side can still take
// one sample into a stall. Configuration writes take effect on the next clock.
module debounced_heater_setpoint_panel_unit #(
    parameter int BAR_COUNT = 2
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [dhsp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dhsp_pkg::CFG_DAT_W-1:0] cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          power_raw,
    input  wire logic                          lower_raw,
    input  wire logic                          raise_raw,
    input  wire logic [dhsp_pkg::TIME_W-1:0]   now_ms,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [dhsp_pkg::BAR_W-1:0]         active_bar,
    output logic [dhsp_pkg::DUTY_W-1:0]        pwm_duty,
    output logic [dhsp_pkg::TEMP_W-1:0]        target_temp,
    output logic                               bar_changed,
    output logic                               long_press_reset
);
    import dhsp_pkg::*;

    localparam int NUM_BTN = 3;
    localparam logic [BAR_W-1:0] BAR_LAST = BAR_W'(BAR_COUNT - 1);

    // configuration registers
    logic [MS_W-1:0]   debounce_reg;
    logic [MS_W-1:0]   long_reg;
    logic [STEP_W-1:0] step_reg;
    logic [TEMP_W-1:0] default_reg;
    logic [TEMP_W-1:0] max_reg;

    // input stage
    logic              s1_valid_reg;
    logic [NUM_BTN-1:0] raw_reg;
    logic [TIME_W-1:0] now_reg;
    logic              advance;

    // panel state
    logic [TEMP_W-1:0] target_reg;
    logic [TEMP_W-1:0] target_next;
    logic [BAR_W-1:0]  bar_reg;
    logic [BAR_W-1:0]  bar_next;
    logic              changed;
    logic              longp;

    btn_status_t       btn [NUM_BTN];

    logic [TEMP_W-1:0] t_base;
    logic [TEMP_W-1:0] t_low;
    logic [TEMP_W:0]   t_up;

    // result register
    logic              out_valid_reg;
    logic [BAR_W-1:0]  bar_out_reg;
    logic [TEMP_W-1:0] target_out_reg;
    logic              changed_out_reg;
    logic              longp_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            long_reg     <= LONG_RST;
            step_reg     <= STEP_RST;
            default_reg  <= DEFAULT_RST;
            max_reg      <= MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE: debounce_reg <= cfg_wdata[MS_W-1:0];
                REG_LONG:     long_reg     <= cfg_wdata[MS_W-1:0];
                REG_STEP:     step_reg     <= cfg_wdata[STEP_W-1:0];
                REG_DEFAULT:  default_reg  <= cfg_wdata[TEMP_W-1:0];
                REG_MAX:      max_reg      <= cfg_wdata[TEMP_W-1:0];
                default:      ;
            endcase
        end
    end

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            raw_reg <= {raise_raw, lower_raw, power_raw};
            now_reg <= now_ms;
        end
    end

    // index 0 power, 1 lower, 2 raise
    for (genvar k = 0; k < NUM_BTN; k++)
    begin : g_btn
        dhsp_debounce u_debounce (
            .clk         (clk),
            .rst_n       (rst_n),
            .update      (advance),
            .raw_level   (raw_reg[k]),
            .now_ms      (now_reg),
            .debounce_ms (debounce_reg),
            .status      (btn[k])
        );
    end

    always_comb
    begin
        changed = btn[0].rise;
        longp   = btn[0].level && (btn[0].held_ms > {{(TIME_W-MS_W){1'b0}}, long_reg});

        bar_next = bar_reg;
        if (changed)
            bar_next = (bar_reg == BAR_LAST) ? '0 : bar_reg + 1'b1;
        if (longp)
            bar_next = '0;

        t_base = longp ? default_reg : target_reg;

        // step down clamps at zero
        t_low = t_base;
        if (btn[1].rise)
            t_low = (t_base < {{(TEMP_W-STEP_W){1'b0}}, step_reg}) ? '0
                    : t_base - {{(TEMP_W-STEP_W){1'b0}}, step_reg};

        // step up saturates at the maximum
        t_up        = {1'b0, t_low} + {{(TEMP_W+1-STEP_W){1'b0}}, step_reg};
        target_next = t_low;
        if (btn[2].rise)
            target_next = (t_up > {1'b0, max_reg}) ? max_reg : t_up[TEMP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= DEFAULT_RST;
            bar_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                target_reg <= target_next;
                bar_reg    <= bar_next;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            bar_out_reg     <= bar_next;
            target_out_reg  <= target_next;
            changed_out_reg <= changed;
            longp_out_reg   <= longp;
        end
    end

    assign out_valid        = out_valid_reg;
    assign active_bar       = bar_out_reg;
    assign target_temp      = target_out_reg;
    assign pwm_duty         = target_out_reg[TEMP_W-1:TEMP_W-DUTY_W];
    assign bar_changed      = changed_out_reg;
    assign long_press_reset = longp_out_reg;

`ifndef SYNTHESIS
    // a long press always leaves the bar at zero
    a_long_press_bar: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && long_press_reset |-> active_bar == '0)
        else $error("long press reset did not clear the bar");

    a_bar_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> {1'b0, active_bar} < (BAR_W+1)'(BAR_COUNT))
        else $error("active bar beyond bar count");

    // input side only stalls when a sample waits behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid && !out_ready)
        else $error("input stalled without a held result");

    // a held result keeps its setpoint and stays valid
    a_hold_target: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(target_temp) && out_valid)
        else $error("held result changed");
`endif

endmodule

`default_nettype wire

// File: sim/debounced_heater_setpoint_panel_unit_test.sv
// self-checking testbench for the heater setpoint panel top level
// needs dhsp_pkg and debounced_heater_setpoint_panel_unit; reads no files
module debounced_heater_setpoint_panel_unit_test;
    import dhsp_pkg::*;

    localparam int BAR_COUNT      = 2;
    localparam int ITEM_TARGET    = 1950;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 4;
    // index with no register behind it, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;

    typedef struct packed {
        logic [BAR_W-1:0]  bar;
        logic [DUTY_W-1:0] duty;
        logic [TEMP_W-1:0] target;
        logic              changed;
        logic              long_reset;
    } panel_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_wdata;
    logic                 in_valid;
    logic                 in_ready;
    logic                 power_raw;
    logic                 lower_raw;
    logic                 raise_raw;
    logic [TIME_W-1:0]    now_ms;
    logic                 out_valid;
    logic                 out_ready;
    logic [BAR_W-1:0]     active_bar;
    logic [DUTY_W-1:0]    pwm_duty;
    logic [TEMP_W-1:0]    target_temp;
    logic                 bar_changed;
    logic                 long_press_reset;

    bit no_idle;
    bit long_stall_req;
    int samples_sent;
    int settings_used;
    bit btn_level [3];
    int btn_hold [3];

    class setpoint_scoreboard;
        logic [MS_W-1:0]   debounce_ms = DEBOUNCE_RST;
        logic [MS_W-1:0]   hold_ms     = LONG_RST;
        logic [STEP_W-1:0] step_size   = STEP_RST;
        logic [TEMP_W-1:0] dflt        = DEFAULT_RST;
        logic [TEMP_W-1:0] tmax        = MAX_RST;
        bit                level [3];
        bit                last_raw [3];
        logic [TIME_W-1:0] changed_at [3] = '{default: '0};
        logic [TEMP_W-1:0] target = DEFAULT_RST;
        logic [BAR_W-1:0]  bar = '0;
        panel_result_t     expected_q [$];
        int                mismatches;
        int                results_checked;
        int                bar_steps;
        int                long_resets;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                REG_DEBOUNCE: debounce_ms = val;
                REG_LONG:     hold_ms = val;
                REG_STEP:     step_size = val[STEP_W-1:0];
                REG_DEFAULT:  dflt = val[TEMP_W-1:0];
                REG_MAX:      tmax = val[TEMP_W-1:0];
                default:      ;
            endcase
        endfunction

        // one accepted sample tick gives exactly one expected result
        function void note_sample(bit p, bit l, bit r, logic [TIME_W-1:0] now);
            bit                raw [3];
            bit                prev [3];
            logic [TIME_W-1:0] elapsed;
            logic [TEMP_W:0]   raised;
            panel_result_t     res;
            raw[0] = p;
            raw[1] = l;
            raw[2] = r;
            res = '0;
            for (int k = 0; k < 3; k++)
            begin
                prev[k] = level[k];
                if (raw[k] != last_raw[k])
                    changed_at[k] = now;
                elapsed = now - changed_at[k];
                if (elapsed > debounce_ms)
                    level[k] = raw[k];
                last_raw[k] = raw[k];
            end
            if (level[0] && !prev[0])
            begin
                bar = BAR_W'((int'(bar) + 1) % BAR_COUNT);
                res.changed = 1'b1;
                bar_steps++;
            end
            // long press is timed from the last raw change of power
            elapsed = now - changed_at[0];
            if (level[0] && elapsed > hold_ms)
            begin
                target = dflt;
                bar = '0;
                res.long_reset = 1'b1;
                long_resets++;
            end
            if (level[1] && !prev[1])
                target = (target < step_size) ? '0 : target - step_size;
            if (level[2] && !prev[2])
            begin
                raised = {1'b0, target} + step_size;
                target = (raised > tmax) ? tmax : raised[TEMP_W-1:0];
            end
            res.bar = bar;
            res.duty = target[TEMP_W-1:2];
            res.target = target;
            expected_q.push_back(res);
        endfunction

        function void check_result(panel_result_t got);
            panel_result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing expected: bar %0d duty %0d target %0d",
                             got.bar, got.duty, got.target);
                return;
            end
            want = expected_q.pop_front();
            results_checked++;
            if (got.bar !== want.bar || got.duty !== want.duty || got.target !== want.target
                || got.changed !== want.changed || got.long_reset !== want.long_reset)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch on result %0d: expected bar %0d duty %0d target %0d %s",
                             results_checked, want.bar, want.duty, want.target, "");
                    $display("  expected changed %0b long %0b", want.changed,
                             want.long_reset);
                    $display("  got bar %0d duty %0d target %0d changed %0b long %0b",
                             got.bar, got.duty, got.target, got.changed, got.long_reset);
                end
            end
        endfunction
    endclass

    setpoint_scoreboard sb = new();

    debounced_heater_setpoint_panel_unit #(
        .BAR_COUNT(BAR_COUNT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .power_raw(power_raw),
        .lower_raw(lower_raw),
        .raise_raw(raise_raw),
        .now_ms(now_ms),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .active_bar(active_bar),
        .pwm_duty(pwm_duty),
        .target_temp(target_temp),
        .bar_changed(bar_changed),
        .long_press_reset(long_press_reset)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic send_sample(bit p, bit l, bit r, logic [TIME_W-1:0] now);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        power_raw <= p;
        lower_raw <= l;
        raise_raw <= r;
        now_ms    <= now;
        do @(posedge clk); while (!in_ready);
        sb.note_sample(p, l, r, now);
        samples_sent++;
    endtask

    // wait for every result, then idle so the pipeline is empty
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic load_settings(logic [CFG_DAT_W-1:0] deb, logic [CFG_DAT_W-1:0] hold,
                                 logic [CFG_DAT_W-1:0] step_val, logic [CFG_DAT_W-1:0] dflt,
                                 logic [CFG_DAT_W-1:0] tmax);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_LONG, hold);
        write_reg(REG_STEP, step_val);
        write_reg(REG_DEFAULT, dflt);
        write_reg(REG_MAX, tmax);
        write_reg(REG_UNUSED, CFG_DAT_W'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // button presses with random hold lengths, short holds act as contact bounce
    task automatic run_buttons(int n, int dt_max, bit noise, bit with_stall,
                               logic [TIME_W-1:0] start);
        logic [TIME_W-1:0] clock_ms;
        clock_ms = start;
        for (int i = 0; i < n; i++)
        begin
            if (with_stall && i == n / 3)
                long_stall_req = 1'b1;
            if (noise)
                send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), $urandom);
            else
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (btn_hold[k] == 0)
                    begin
                        btn_level[k] = !btn_level[k];
                        btn_hold[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2)
                                                                  : $urandom_range(3, 50);
                    end
                    btn_hold[k]--;
                end
                clock_ms += $urandom_range(0, dt_max);
                send_sample(btn_level[0], btn_level[1], btn_level[2], clock_ms);
            end
        end
    endtask

    initial
    begin : stimulus
        int dt_max;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_DEBOUNCE;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        power_raw <= 1'b0;
        lower_raw <= 1'b0;
        raise_raw <= 1'b0;
        now_ms    <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: all three rise together, then a held power press
        send_sample(1'b0, 1'b0, 1'b0, 32'd0);
        send_sample(1'b1, 1'b1, 1'b1, 32'd10);
        send_sample(1'b1, 1'b1, 1'b1, 32'd111);
        send_sample(1'b1, 1'b1, 1'b1, 32'd1011);
        send_sample(1'b1, 1'b0, 1'b0, 32'd1500);
        send_sample(1'b0, 1'b0, 1'b0, 32'd1601);
        send_sample(1'b0, 1'b0, 1'b1, 32'd1702);
        send_sample(1'b0, 1'b0, 1'b1, 32'd1803);

        // edge and long press on one tick, raise above the limit, clamp at zero, wrap
        drain_and_settle();
        load_settings(16'd10, 16'd5, 16'd255, 16'hFFFF, 16'd100);
        send_sample(1'b1, 1'b1, 1'b0, 32'd2000);
        send_sample(1'b1, 1'b1, 1'b0, 32'd2011);
        send_sample(1'b0, 1'b0, 1'b1, 32'd2020);
        send_sample(1'b0, 1'b0, 1'b1, 32'd2031);
        send_sample(1'b0, 1'b1, 1'b0, 32'd2040);
        send_sample(1'b0, 1'b1, 1'b0, 32'd2051);
        send_sample(1'b0, 1'b0, 1'b1, 32'hFFFF_FFF8);
        send_sample(1'b0, 1'b0, 1'b1, 32'h0000_0003);

        // all registers zero
        drain_and_settle();
        load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_sample(1'b1, 1'b0, 1'b1, 32'd5);
        send_sample(1'b1, 1'b0, 1'b1, 32'd6);
        send_sample(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_sample(1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF);

        drain_and_settle();
        load_settings(16'd8, 16'd80, 16'd20, 16'd400, 16'd1020);
        run_buttons(300, 4, 1'b0, 1'b0, $urandom);

        // largest times, timestamps wrap during the phase
        drain_and_settle();
        load_settings(16'hFFFF, 16'hFFFF, 16'd255, 16'd1020, 16'd1020);
        run_buttons(150, 30000, 1'b0, 1'b0, 32'hFFF0_0000);

        // back-to-back samples while the result side holds off
        drain_and_settle();
        no_idle = 1'b1;
        load_settings(16'd2, 16'd12, 16'd33, 16'd999, 16'd1000);
        run_buttons(250, 2, 1'b0, 1'b1, $urandom);
        no_idle = 1'b0;

        drain_and_settle();
        load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_buttons(120, 3, 1'b0, 1'b0, $urandom);

        // random levels and timestamps on every tick
        drain_and_settle();
        load_settings(CFG_DAT_W'($urandom_range(0, 200)), CFG_DAT_W'($urandom_range(0, 2000)),
                      CFG_DAT_W'($urandom), CFG_DAT_W'($urandom), CFG_DAT_W'($urandom));
        run_buttons(150, 0, 1'b1, 1'b0, '0);

        while (samples_sent < ITEM_TARGET)
        begin
            drain_and_settle();
            dt_max = $urandom_range(1, 8);
            no_idle = ($urandom_range(0, 3) == 0);
            load_settings(CFG_DAT_W'($urandom_range(0, 3 * dt_max)),
                          CFG_DAT_W'($urandom_range(0, 20 * dt_max)),
                          CFG_DAT_W'($urandom), CFG_DAT_W'($urandom), CFG_DAT_W'($urandom));
            run_buttons($urandom_range(100, 200), dt_max, 1'b0, 1'b0, $urandom);
        end
        no_idle = 1'b0;
        drain_and_settle();

        $display("%0d sample ticks under %0d register settings, %0d results checked, %0d bad",
                 samples_sent, settings_used, sb.results_checked, sb.mismatches);
        $display("bar advanced %0d times, long-press reset seen on %0d ticks",
                 sb.bar_steps, sb.long_resets);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : result_sink
        panel_result_t got;
        int            gap;
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got.bar        = active_bar;
                got.duty       = pwm_duty;
                got.target     = target_temp;
                got.changed    = bar_changed;
                got.long_reset = long_press_reset;
                sb.check_result(got);
                gap = no_idle ? 0 : $urandom_range(0, 11);
                if (long_stall_req)
                begin
                    gap = LONG_HOLD;
                    long_stall_req = 1'b0;
                end
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                    out_ready <= 1'b1;
                end
            end
        end
    end

    // any transaction on either side restarts the count
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
